### rtl/gne_pkg.sv
package gne_pkg;

  // Default size of the bitmap store; coordinates are 6 bits wide, so at most
  // COORD_LIM rows and columns are ever addressed.
  localparam int GNE_MAX_ROWS = 64;
  localparam int GNE_MAX_COLS = 64;
  localparam int COORD_LIM    = 64;

  localparam int COORD_W  = 6;
  localparam int DIM_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  typedef enum logic [2:0] {
    ACT_WR_OBS  = 3'd0,
    ACT_MARK    = 3'd1,
    ACT_CLR_EXP = 3'd2,
    ACT_QUERY   = 3'd3,
    ACT_EXPAND  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_SUCC    = 2'd0,
    KIND_NONE    = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  // Which row of the 3x3 window around the addressed cell is read or captured.
  typedef enum logic [1:0] {
    ROW_UP   = 2'd0,
    ROW_MID  = 2'd1,
    ROW_DOWN = 2'd2
  } rsel_e;

  // Move offsets in expansion order.
  localparam logic signed [1:0] MOVE_DR [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] MOVE_DC [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                -2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef struct packed {
    logic  load_item;
    logic  rd_en;
    rsel_e rd_sel;
    logic  cap_en;
    rsel_e cap_sel;
    logic  wr_obs;
    logic  wr_exp;
    logic  clr_step;
    logic  clr_obs;
    logic  mask_load;
    logic  out_load;
    kind_e out_kind;
  } gne_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       cell_ok;
    logic       mask_empty;
    logic       mask_last;
    logic       slot_free;
    logic       sweep_last;
  } gne_stat_t;

endpackage

### rtl/gne_datapath.sv
module gne_datapath #(
  parameter int MAX_ROWS = gne_pkg::GNE_MAX_ROWS,
  parameter int MAX_COLS = gne_pkg::GNE_MAX_COLS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gne_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gne_pkg::DIM_W-1:0]           cfg_wdata_i,
  input  logic [gne_pkg::IN_DATA_W-1:0]       item_data_i,
  input  logic [gne_pkg::IN_USER_W-1:0]       item_user_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [gne_pkg::OUT_DATA_W-1:0]      out_data_o,
  output logic [gne_pkg::OUT_USER_W-1:0]      out_kind_o,
  output logic                                out_last_o,
  input  gne_pkg::gne_cmd_t                   cmd_i,
  output gne_pkg::gne_stat_t                  stat_o
);
  import gne_pkg::*;

  localparam int ROWS_EFF = (MAX_ROWS < COORD_LIM) ? MAX_ROWS : COORD_LIM;
  localparam int COLS_EFF = (MAX_COLS < COORD_LIM) ? MAX_COLS : COORD_LIM;
  localparam int RW = $clog2(ROWS_EFF);
  localparam int CW = $clog2(COLS_EFF);

  // Configuration.
  logic [DIM_W-1:0] grid_rows_q, grid_cols_q;
  logic [DIM_W-1:0] rows_used, cols_used;

  // Item registers.
  logic [2:0]         action_q;
  logic [COORD_W-1:0] row_q, col_q;
  logic               value_q;

  // Row memories, one row of cells per word.
  logic [COLS_EFF-1:0] obs_mem [ROWS_EFF];
  logic [COLS_EFF-1:0] exp_mem [ROWS_EFF];
  logic [COLS_EFF-1:0] obs_rd_q, exp_rd_q;
  logic [COLS_EFF-1:0] obs_wdata, exp_wdata;
  logic                obs_we, exp_we;
  logic [RW-1:0]       rd_addr, wr_addr, row_idx;
  logic [CW-1:0]       col_idx, col_m1, col_p1;
  logic [RW-1:0]       sweep_q;

  // 3x3 window of obstacle and explored bits, [window row][window column].
  logic [2:0][2:0] win_obs_q, win_exp_q;
  logic [2:0]      row_ok, col_ok;
  logic [7:0]      mask_q, mask_d;
  logic [2:0]      sel;
  logic [7:0]      mask_rest;

  logic               out_vld_q;
  logic [1:0]         kind_q;
  logic [COORD_W-1:0] orow_q, ocol_q;
  logic [2:0]         omove_q;
  logic               oobs_q, oexp_q, olast_q;

  assign rows_used = (grid_rows_q > DIM_W'(ROWS_EFF)) ? DIM_W'(ROWS_EFF) : grid_rows_q;
  assign cols_used = (grid_cols_q > DIM_W'(COLS_EFF)) ? DIM_W'(COLS_EFF) : grid_cols_q;

  assign row_idx = row_q[RW-1:0];
  assign col_idx = col_q[CW-1:0];
  assign col_m1  = col_idx - 1'b1;
  assign col_p1  = col_idx + 1'b1;

  assign row_ok = {({1'b0, row_q} + 1'b1) < rows_used, 1'b1, row_q != '0};
  assign col_ok = {({1'b0, col_q} + 1'b1) < cols_used, 1'b1, col_q != '0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= DIM_W'(COORD_LIM);
      grid_cols_q <= DIM_W'(COORD_LIM);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_GRID_ROWS) grid_rows_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_GRID_COLS) grid_cols_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= item_user_i;
      row_q    <= item_data_i[5:0];
      col_q    <= item_data_i[11:6];
      value_q  <= item_data_i[12];
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      ROW_UP:   rd_addr = row_idx - 1'b1;
      ROW_DOWN: rd_addr = row_idx + 1'b1;
      default:  rd_addr = row_idx;
    endcase
  end

  // Read-modify-write of one cell, or a zero row during a clearing pass.
  always_comb begin
    obs_wdata = obs_rd_q;
    exp_wdata = exp_rd_q;
    obs_wdata[col_idx] = value_q;
    exp_wdata[col_idx] = 1'b1;
    wr_addr = row_idx;
    obs_we  = cmd_i.wr_obs;
    exp_we  = cmd_i.wr_exp;
    if (cmd_i.clr_step) begin
      obs_wdata = '0;
      exp_wdata = '0;
      wr_addr   = sweep_q;
      obs_we    = cmd_i.clr_obs;
      exp_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (obs_we) obs_mem[wr_addr] <= obs_wdata;
    if (exp_we) exp_mem[wr_addr] <= exp_wdata;
    if (cmd_i.rd_en) begin
      obs_rd_q <= obs_mem[rd_addr];
      exp_rd_q <= exp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.clr_step) begin
      sweep_q <= stat_o.sweep_last ? '0 : sweep_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      win_obs_q[cmd_i.cap_sel] <= {obs_rd_q[col_p1], obs_rd_q[col_idx], obs_rd_q[col_m1]};
      win_exp_q[cmd_i.cap_sel] <= {exp_rd_q[col_p1], exp_rd_q[col_idx], exp_rd_q[col_m1]};
    end
  end

  // Qualifying moves: inside the grid and free of obstacles.
  always_comb begin
    logic [1:0] wr, wc;
    for (int m = 0; m < 8; m++) begin
      wr = 2'(MOVE_DR[m]) + 2'd1;
      wc = 2'(MOVE_DC[m]) + 2'd1;
      mask_d[m] = row_ok[wr] & col_ok[wc] & ~win_obs_q[wr][wc];
    end
  end

  always_comb begin
    sel = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_q[i]) sel = 3'(i);
    end
  end

  assign mask_rest = mask_q & ~(8'd1 << sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cmd_i.mask_load) begin
      mask_q <= mask_d;
    end else if (cmd_i.out_load && cmd_i.out_kind == KIND_SUCC) begin
      mask_q <= mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q  <= cmd_i.out_kind;
      orow_q  <= row_q;
      ocol_q  <= col_q;
      omove_q <= 3'd0;
      oobs_q  <= 1'b0;
      oexp_q  <= 1'b0;
      olast_q <= 1'b1;
      case (cmd_i.out_kind)
        KIND_QUERY: begin
          oobs_q <= win_obs_q[1][1];
          oexp_q <= win_exp_q[1][1];
        end
        KIND_SUCC: begin
          orow_q  <= row_q + {{(COORD_W-2){MOVE_DR[sel][1]}}, MOVE_DR[sel]};
          ocol_q  <= col_q + {{(COORD_W-2){MOVE_DC[sel][1]}}, MOVE_DC[sel]};
          omove_q <= sel;
          oexp_q  <= win_exp_q[2'(MOVE_DR[sel]) + 2'd1][2'(MOVE_DC[sel]) + 2'd1];
          olast_q <= (mask_rest == '0);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {7'd0, oexp_q, oobs_q, omove_q, ocol_q, orow_q};
  assign out_kind_o  = kind_q;
  assign out_last_o  = olast_q;

  assign stat_o.action     = action_q;
  assign stat_o.cell_ok    = ({1'b0, row_q} < rows_used) && ({1'b0, col_q} < cols_used);
  assign stat_o.mask_empty = (mask_q == '0);
  assign stat_o.mask_last  = (mask_rest == '0);
  assign stat_o.slot_free  = ~out_vld_q | out_ready_i;
  assign stat_o.sweep_last = (sweep_q == RW'(ROWS_EFF - 1));

  a_clr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_step |-> !(cmd_i.wr_obs || cmd_i.wr_exp))
    else $error("clearing pass collides with a cell write");

endmodule

### rtl/gne_ctrl.sv
module gne_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output gne_pkg::gne_cmd_t   cmd_o,
  input  gne_pkg::gne_stat_t  stat_i
);
  import gne_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR_ALL, ST_IDLE, ST_DECODE, ST_W_RD, ST_W_WR, ST_Q_RD, ST_Q_CAP,
    ST_RESP, ST_E_R0, ST_E_R1, ST_E_R2, ST_E_C2, ST_E_MASK, ST_EMIT, ST_CLR_EXP
  } state_e;

  state_e state_q;
  kind_e  resp_kind_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o & in_valid_i;

  always_comb begin
    cmd_o = '0;
    cmd_o.rd_sel   = ROW_MID;
    cmd_o.cap_sel  = ROW_MID;
    cmd_o.out_kind = resp_kind_q;
    case (state_q)
      ST_CLR_ALL: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.clr_obs  = 1'b1;
      end
      ST_CLR_EXP: cmd_o.clr_step = 1'b1;
      ST_IDLE:    cmd_o.load_item = accept;
      ST_W_RD, ST_Q_RD: cmd_o.rd_en = 1'b1;
      ST_W_WR: begin
        cmd_o.wr_obs = (stat_i.action == ACT_WR_OBS);
        cmd_o.wr_exp = (stat_i.action == ACT_MARK);
      end
      ST_Q_CAP: cmd_o.cap_en = 1'b1;
      ST_RESP:  cmd_o.out_load = stat_i.slot_free;
      ST_E_R0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ROW_UP;
      end
      ST_E_R1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = ROW_UP;
      end
      ST_E_R2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ROW_DOWN;
        cmd_o.cap_en = 1'b1;
      end
      ST_E_C2: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = ROW_DOWN;
      end
      ST_E_MASK: cmd_o.mask_load = 1'b1;
      ST_EMIT: begin
        cmd_o.out_load = stat_i.slot_free & ~stat_i.mask_empty;
        cmd_o.out_kind = KIND_SUCC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR_ALL;
      resp_kind_q <= KIND_INVALID;
    end else begin
      case (state_q)
        ST_CLR_ALL, ST_CLR_EXP: begin
          if (stat_i.sweep_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) state_q <= ST_DECODE;
        end
        ST_DECODE: begin
          resp_kind_q <= KIND_INVALID;
          case (stat_i.action)
            ACT_WR_OBS, ACT_MARK: state_q <= stat_i.cell_ok ? ST_W_RD : ST_IDLE;
            ACT_CLR_EXP:          state_q <= ST_CLR_EXP;
            ACT_QUERY:            state_q <= stat_i.cell_ok ? ST_Q_RD : ST_RESP;
            ACT_EXPAND:           state_q <= stat_i.cell_ok ? ST_E_R0 : ST_RESP;
            default:              state_q <= ST_IDLE;
          endcase
        end
        ST_W_RD:  state_q <= ST_W_WR;
        ST_W_WR:  state_q <= ST_IDLE;
        ST_Q_RD:  state_q <= ST_Q_CAP;
        ST_Q_CAP: begin
          resp_kind_q <= KIND_QUERY;
          state_q     <= ST_RESP;
        end
        ST_RESP: begin
          if (stat_i.slot_free) state_q <= ST_IDLE;
        end
        ST_E_R0:   state_q <= ST_E_R1;
        ST_E_R1:   state_q <= ST_E_R2;
        ST_E_R2:   state_q <= ST_E_C2;
        ST_E_C2:   state_q <= ST_E_MASK;
        ST_E_MASK: state_q <= ST_EMIT;
        ST_EMIT: begin
          if (stat_i.mask_empty) begin
            resp_kind_q <= KIND_NONE;
            state_q     <= ST_RESP;
          end else if (stat_i.slot_free && stat_i.mask_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DECODE) && !in_ready_o)
    else $error("accepted request not decoded in the next cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.slot_free)
    else $error("result loaded over one that was not taken");

  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_obs || cmd_o.wr_exp) |-> $past(cmd_o.rd_en))
    else $error("cell write without a preceding row read");

endmodule

### rtl/grid_neighbor_expander_core.sv
// Channel   | Direction | Signals
// ----------+-----------+---------------------------------------------------------
// s_axis    | in        | tvalid, tready, tdata (row, col, value), tuser (action)
// m_axis    | out       | tvalid, tready, tdata (row, col, move, obstacle,
//           |           | explored), tuser (kind), tlast
// cfg       | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i (grid_rows, grid_cols)
//
// One request is handled at a time. A write or mark inside the grid reads the cell's row and
// writes it back; a query reads the row and captures the window; an expansion reads three rows,
// builds the move mask and emits each successor, or a none result; a clear of the explored map
// sweeps R = min(MAX_ROWS, 64) rows. Outside the grid a query or expansion is answered as invalid.
// After reset a clearing pass over the R rows of both bitmaps runs before the first request.
// An m_axis stall holds the result and freezes the block only when a new one must be loaded.
module grid_neighbor_expander_core #(
  parameter int MAX_ROWS = gne_pkg::GNE_MAX_ROWS,
  parameter int MAX_COLS = gne_pkg::GNE_MAX_COLS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port: index 0 grid_rows, index 1 grid_cols.
  input  logic                              cfg_we_i,
  input  logic [gne_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gne_pkg::DIM_W-1:0]         cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: row [5:0], col [11:6], value [12], zero [15:13].
  input  logic [gne_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: action [2:0].
  input  logic [gne_pkg::IN_USER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: out_row [5:0], out_col [11:6], move_index [14:12],
  // obstacle [15], explored [16], zero [23:17].
  output logic [gne_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: kind [1:0].
  output logic [gne_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tlast
);
  import gne_pkg::*;

  gne_cmd_t  cmd;
  gne_stat_t stat;

  // The controller sequences each request; the datapath holds the bitmaps,
  // the 3x3 neighborhood window, the move mask and the output register.
  gne_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  gne_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_data_i (s_axis_tdata),
    .item_user_i (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
